// ===== rtl/core/http_response_stream_parser_top_assert.svh =====
// Assertion macros for the response parser; empty when synthesising.
`ifndef HTTP_RESPONSE_STREAM_PARSER_TOP_ASSERT_SVH
`define HTTP_RESPONSE_STREAM_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define HRSP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hrsp: implication failed");
`define HRSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("hrsp: next-cycle check failed");
`else
`define HRSP_ASSERT_IMPLIES(label, ante, cons)
`define HRSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/hrsp_pkg.sv =====
package hrsp_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic        body_valid;
        logic        done_res;
        logic [9:0]  status_code;
        logic [31:0] body_length;
        logic        is_error;
    } out_t;

    // Byte classes worked out ahead of the parser
    typedef struct packed {
        logic       nul;
        logic       lf;
        logic       cr;
        logic       ws;
        logic       space;
        logic       colon;
        logic       plus;
        logic       minus;
        logic       xchar;
        logic       is_dig;
        logic [3:0] dig;
        logic       hex_ok;
        logic [3:0] hexd;
    } cls_t;

    typedef struct packed {
        in_t  data;
        cls_t cls;
    } entry_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [9:0] ERR_STATUS = 10'd400;
    localparam logic [9:0] MAX_STATUS = 10'd999;

    function automatic logic [7:0] k_stat(input logic [4:0] p);
        unique case (p)
            5'd0: k_stat = "H";
            5'd1: k_stat = "T";
            5'd2: k_stat = "T";
            5'd3: k_stat = "P";
            5'd4: k_stat = "/";
            default: k_stat = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] k_clen(input logic [4:0] p);
        unique case (p)
            5'd0:  k_clen = "C";
            5'd1:  k_clen = "o";
            5'd2:  k_clen = "n";
            5'd3:  k_clen = "t";
            5'd4:  k_clen = "e";
            5'd5:  k_clen = "n";
            5'd6:  k_clen = "t";
            5'd7:  k_clen = "-";
            5'd8:  k_clen = "L";
            5'd9:  k_clen = "e";
            5'd10: k_clen = "n";
            5'd11: k_clen = "g";
            5'd12: k_clen = "t";
            5'd13: k_clen = "h";
            default: k_clen = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] k_tenc(input logic [4:0] p);
        unique case (p)
            5'd0:  k_tenc = "T";
            5'd1:  k_tenc = "r";
            5'd2:  k_tenc = "a";
            5'd3:  k_tenc = "n";
            5'd4:  k_tenc = "s";
            5'd5:  k_tenc = "f";
            5'd6:  k_tenc = "e";
            5'd7:  k_tenc = "r";
            5'd8:  k_tenc = "-";
            5'd9:  k_tenc = "E";
            5'd10: k_tenc = "n";
            5'd11: k_tenc = "c";
            5'd12: k_tenc = "o";
            5'd13: k_tenc = "d";
            5'd14: k_tenc = "i";
            5'd15: k_tenc = "n";
            5'd16: k_tenc = "g";
            default: k_tenc = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] k_chunk(input logic [3:0] p);
        unique case (p)
            4'd0: k_chunk = "c";
            4'd1: k_chunk = "h";
            4'd2: k_chunk = "u";
            4'd3: k_chunk = "n";
            4'd4: k_chunk = "k";
            4'd5: k_chunk = "e";
            4'd6: k_chunk = "d";
            4'd7: k_chunk = 8'h0d;
            4'd8: k_chunk = 8'h0a;
            default: k_chunk = 8'h00;
        endcase
    endfunction

endpackage

// ===== rtl/core/hrsp_front.sv =====
module hrsp_front
    import hrsp_pkg::*;
(
    input  in_t    in_data,
    output entry_t entry
);

    logic [7:0] b;

    assign b = in_data.rx_byte;

    // Classify the byte for the parser
    always_comb begin
        entry.data       = in_data;
        entry.cls.nul    = (b == 8'h00);
        entry.cls.lf     = (b == 8'h0a);
        entry.cls.cr     = (b == 8'h0d);
        entry.cls.ws     = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
        entry.cls.space  = (b == 8'h20);
        entry.cls.colon  = (b == ":");
        entry.cls.plus   = (b == "+");
        entry.cls.minus  = (b == "-");
        entry.cls.xchar  = (b == "x") || (b == "X");
        entry.cls.is_dig = (b >= "0") && (b <= "9");
        entry.cls.dig    = b[3:0];
        entry.cls.hex_ok = 1'b1;
        entry.cls.hexd   = b[3:0];
        if (b >= "0" && b <= "9") begin
            entry.cls.hexd = b[3:0];
        end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            entry.cls.hexd = b[3:0] + 4'd9;
        end else begin
            entry.cls.hex_ok = 1'b0;
        end
    end

endmodule

// ===== rtl/core/hrsp_queue.sv =====
module hrsp_queue
    import hrsp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   not_full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    entry_t             mem_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg;
    logic [QAW-1:0]     rd_ptr_reg;
    logic [QAW:0]       count_reg;

    assign not_full  = (count_reg != (QAW+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Store requests
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/hrsp_back.sv =====
module hrsp_back
    import hrsp_pkg::*;
#(
    parameter int LW = 32
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_valid,
    input  entry_t q_head,
    output logic   q_pop,
    output logic   m_valid,
    input  logic   m_ready,
    output out_t   m_data
);

    typedef enum logic [3:0] {
        PH_HDR, PH_CRSKIP, PH_HALT, PH_CLEN, PH_CSIZE, PH_CDATA, PH_CGAP, PH_PLAIN, PH_FIN
    } phase_t;

    typedef struct packed {
        logic [2:0]    st;
        logic [LW-1:0] v;
    } num_r_t;

    localparam logic [2:0] DS_SPACE  = 3'd0;
    localparam logic [2:0] DS_DIGITS = 3'd1;
    localparam logic [2:0] DS_STOP   = 3'd2;
    localparam logic [2:0] DS_NEG    = 3'd3;
    localparam logic [2:0] HS_SPACE  = 3'd0;
    localparam logic [2:0] HS_SIGN   = 3'd1;
    localparam logic [2:0] HS_DIGITS = 3'd2;
    localparam logic [2:0] HS_ZERO   = 3'd3;
    localparam logic [2:0] HS_X      = 3'd4;
    localparam logic [2:0] HS_STOP   = 3'd5;
    localparam logic [2:0] HS_NEG    = 3'd6;

    localparam logic [1:0] HK_NONE  = 2'd0;
    localparam logic [1:0] HK_CLEN  = 2'd1;
    localparam logic [1:0] HK_TENC  = 2'd2;

    localparam logic [3:0] VM_FULL = 4'd9;
    localparam logic [3:0] VM_FAIL = 4'd15;

    localparam logic [LW-1:0] LMAX = '1;

    // Decimal digit feed, saturating at vmax
    function automatic num_r_t dec_feed(input logic [2:0] st, input cls_t c,
                                        input logic [LW-1:0] v, input logic [LW-1:0] vmax);
        num_r_t      r;
        logic [LW+3:0] w;
        r.st = st;
        r.v  = v;
        w = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (LW+4)'(c.dig);
        if (st == DS_SPACE) begin
            if (c.ws) begin
                r.st = st;
            end else if (c.plus) begin
                r.st = DS_DIGITS;
            end else if (c.minus) begin
                r.st = DS_NEG;
                r.v  = '0;
            end else if (c.is_dig) begin
                r.st = DS_DIGITS;
                r.v  = LW'(c.dig);
            end else begin
                r.st = DS_STOP;
            end
        end else if (st == DS_DIGITS) begin
            if (c.is_dig) begin
                r.v = (w > {4'b0, vmax}) ? vmax : w[LW-1:0];
            end else begin
                r.st = DS_STOP;
            end
        end
        return r;
    endfunction

    // Hex chunk-size feed, saturating at the length maximum
    function automatic num_r_t hex_feed(input logic [2:0] st, input cls_t c,
                                        input logic [LW-1:0] v);
        num_r_t r;
        logic   zero_ch;
        r.st = st;
        r.v  = v;
        zero_ch = c.is_dig && (c.dig == 4'd0);
        unique case (st)
            HS_SPACE, HS_SIGN: begin
                if (st == HS_SPACE && c.ws) begin
                    r.st = st;
                end else if (st == HS_SPACE && c.plus) begin
                    r.st = HS_SIGN;
                end else if (st == HS_SPACE && c.minus) begin
                    r.st = HS_NEG;
                    r.v  = '0;
                end else if (zero_ch) begin
                    r.st = HS_ZERO;
                end else if (c.hex_ok) begin
                    r.st = HS_DIGITS;
                    r.v  = LW'(c.hexd);
                end else begin
                    r.st = HS_STOP;
                end
            end
            HS_ZERO, HS_X: begin
                if (st == HS_ZERO && c.xchar) begin
                    r.st = HS_X;
                end else if (c.hex_ok) begin
                    r.st = HS_DIGITS;
                    r.v  = LW'(c.hexd);
                end else begin
                    r.st = HS_STOP;
                end
            end
            HS_DIGITS: begin
                if (c.hex_ok) begin
                    r.v = (|v[LW-1:LW-4]) ? LMAX : {v[LW-5:0], c.hexd};
                end else begin
                    r.st = HS_STOP;
                end
            end
            default: r.st = st;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] len_out(input logic [LW-1:0] v);
        logic [63:0] e;
        e = 64'(v);
        return (|e[63:32]) ? 32'hffff_ffff : e[31:0];
    endfunction

    phase_t        phase_reg, phase_next;
    logic [4:0]    lpos_reg, lpos_next;
    logic [1:0]    nmf_reg, nmf_next;
    logic [3:0]    vmp_reg, vmp_next;
    logic [9:0]    status_reg, status_next;
    logic [LW-1:0] clen_reg, clen_next;
    logic          lpres_reg, lpres_next;
    logic          chunked_reg, chunked_next;
    logic [LW-1:0] crem_reg, crem_next;
    logic [LW-1:0] dcount_reg, dcount_next;
    logic [1:0]    skip_reg, skip_next;
    logic          pfx_reg, pfx_next;
    logic          on_status_reg, on_status_next;
    logic          colon_reg, colon_next;
    logic          past_first_reg, past_first_next;
    logic          space_seen_reg, space_seen_next;
    logic          body_started_reg, body_started_next;
    logic [1:0]    kind_reg, kind_next;
    logic [2:0]    nst_reg, nst_next;
    logic          m_valid_reg;
    out_t          m_data_reg;
    logic          res_valid;
    out_t          res_data;

    logic [7:0]    b;
    cls_t          c;
    num_r_t        nr;
    logic [LW-1:0] len_sel;

    assign b     = q_head.data.rx_byte;
    assign c     = q_head.cls;
    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Work out the next parser state and any result for the head request
    always_comb begin
        phase_next        = phase_reg;
        lpos_next         = lpos_reg;
        nmf_next          = nmf_reg;
        vmp_next          = vmp_reg;
        status_next       = status_reg;
        clen_next         = clen_reg;
        lpres_next        = lpres_reg;
        chunked_next      = chunked_reg;
        crem_next         = crem_reg;
        dcount_next       = dcount_reg;
        skip_next         = skip_reg;
        pfx_next          = pfx_reg;
        on_status_next    = on_status_reg;
        colon_next        = colon_reg;
        past_first_next   = past_first_reg;
        space_seen_next   = space_seen_reg;
        body_started_next = body_started_reg;
        kind_next         = kind_reg;
        nst_next          = nst_reg;
        res_valid         = 1'b0;
        res_data          = '0;
        nr                = '0;
        len_sel           = (body_started_reg && lpres_reg) ? clen_reg : dcount_reg;

        if (q_head.data.end_of_stream) begin
            // Emit summary and return to reset state
            res_valid            = 1'b1;
            res_data.done_res    = 1'b1;
            res_data.status_code = status_reg;
            res_data.body_length = len_out(len_sel);
            res_data.is_error    = (status_reg >= ERR_STATUS);
            phase_next        = PH_HDR;
            status_next       = '0;
            clen_next         = '0;
            lpres_next        = 1'b0;
            chunked_next      = 1'b0;
            crem_next         = '0;
            dcount_next       = '0;
            skip_next         = '0;
            body_started_next = 1'b0;
            lpos_next         = '0;
            nmf_next          = 2'b11;
            vmp_next          = '0;
            pfx_next          = 1'b1;
            on_status_next    = 1'b0;
            colon_next        = 1'b0;
            past_first_next   = 1'b0;
            space_seen_next   = 1'b0;
            kind_next         = HK_NONE;
            nst_next          = '0;
        end else begin
            unique case (phase_reg)
                PH_HDR: begin
                    if (c.nul) begin
                        phase_next = PH_HALT;
                    end else if (lpos_reg == '0 && (c.lf || c.cr)) begin
                        if (c.cr) begin
                            phase_next = PH_CRSKIP;
                        end else begin
                            body_started_next = 1'b1;
                            nst_next = '0;
                            if (lpres_reg) begin
                                phase_next = (clen_reg == '0) ? PH_FIN : PH_CLEN;
                            end else if (chunked_reg) begin
                                crem_next  = '0;
                                phase_next = PH_CSIZE;
                            end else begin
                                phase_next = PH_PLAIN;
                            end
                        end
                    end else if (c.lf) begin
                        // Close the line: latch chunked selection and content length, clear line state
                        if (colon_reg && past_first_reg && kind_reg == HK_TENC) begin
                            chunked_next = (vmp_reg == 4'd8);
                        end else if (kind_reg == HK_TENC) begin
                            chunked_next = (vmp_reg == VM_FULL);
                        end
                        if (colon_reg && past_first_reg && kind_reg == HK_CLEN) begin
                            nr = dec_feed(nst_reg, c, clen_reg, LMAX);
                            clen_next = nr.v;
                        end
                        lpos_next       = '0;
                        nmf_next        = 2'b11;
                        vmp_next        = '0;
                        pfx_next        = 1'b1;
                        on_status_next  = 1'b0;
                        colon_next      = 1'b0;
                        past_first_next = 1'b0;
                        space_seen_next = 1'b0;
                        kind_next       = HK_NONE;
                        nst_next        = '0;
                    end else begin
                        if (lpos_reg < 5'd5) begin
                            pfx_next = pfx_reg && (b == k_stat(lpos_reg));
                            if (lpos_reg == 5'd4 && pfx_next) begin
                                on_status_next = 1'b1;
                                status_next    = '0;
                                nst_next       = '0;
                            end
                        end
                        if (on_status_next) begin
                            if (lpos_reg >= 5'd9 && lpos_reg <= 5'd11) begin
                                nr = dec_feed(nst_reg, c, LW'(status_reg), LW'(MAX_STATUS));
                                status_next = nr.v[9:0];
                                nst_next    = nr.st;
                            end
                        end else if (!colon_reg) begin
                            if (c.colon) begin
                                colon_next = 1'b1;
                                if (nmf_reg[0] && lpos_reg == 5'd14) begin
                                    kind_next  = HK_CLEN;
                                    lpres_next = 1'b1;
                                    clen_next  = '0;
                                end else if (nmf_reg[1] && lpos_reg == 5'd17) begin
                                    kind_next = HK_TENC;
                                end else begin
                                    kind_next = HK_NONE;
                                end
                                nst_next = '0;
                                vmp_next = '0;
                            end else begin
                                if (lpos_reg >= 5'd14 || b != k_clen(lpos_reg)) begin
                                    nmf_next[0] = 1'b0;
                                end
                                if (lpos_reg >= 5'd17 || b != k_tenc(lpos_reg)) begin
                                    nmf_next[1] = 1'b0;
                                end
                            end
                        end else if (!past_first_reg) begin
                            past_first_next = 1'b1;
                            space_seen_next = c.space;
                        end else if (c.space && !space_seen_reg) begin
                            // Value restarts after the first space
                            space_seen_next = 1'b1;
                            if (kind_reg == HK_CLEN) begin
                                clen_next = '0;
                            end
                            nst_next = '0;
                            vmp_next = '0;
                        end else if (kind_reg == HK_CLEN) begin
                            nr = dec_feed(nst_reg, c, clen_reg, LMAX);
                            clen_next = nr.v;
                            nst_next  = nr.st;
                        end else if (kind_reg == HK_TENC) begin
                            if (vmp_reg < VM_FULL && b == k_chunk(vmp_reg)) begin
                                vmp_next = vmp_reg + 4'd1;
                            end else begin
                                vmp_next = VM_FAIL;
                            end
                        end
                        lpos_next = (lpos_reg < 5'd31) ? lpos_reg + 5'd1 : 5'd31;
                    end
                end
                PH_CRSKIP: begin
                    if (c.nul) begin
                        phase_next = PH_HALT;
                    end else if (c.lf) begin
                        body_started_next = 1'b1;
                        nst_next = '0;
                        if (lpres_reg) begin
                            phase_next = (clen_reg == '0) ? PH_FIN : PH_CLEN;
                        end else if (chunked_reg) begin
                            crem_next  = '0;
                            phase_next = PH_CSIZE;
                        end else begin
                            phase_next = PH_PLAIN;
                        end
                    end
                end
                PH_CLEN, PH_PLAIN, PH_CDATA: begin
                    if (phase_reg == PH_PLAIN && c.nul) begin
                        phase_next = PH_FIN;
                    end else begin
                        // Deliver a body byte
                        res_valid           = 1'b1;
                        res_data.body_byte  = b;
                        res_data.body_valid = 1'b1;
                        dcount_next = (dcount_reg != LMAX) ? dcount_reg + 1'b1 : dcount_reg;
                        if (phase_reg == PH_CLEN && dcount_next >= clen_reg) begin
                            phase_next = PH_FIN;
                        end
                        if (phase_reg == PH_CDATA) begin
                            crem_next = (crem_reg != '0) ? crem_reg - 1'b1 : crem_reg;
                            if (crem_next == '0) begin
                                phase_next = PH_CGAP;
                                skip_next  = 2'd2;
                            end
                        end
                    end
                end
                PH_CSIZE: begin
                    if (c.nul) begin
                        phase_next = PH_FIN;
                    end else if (c.lf) begin
                        phase_next = (crem_reg == '0) ? PH_FIN : PH_CDATA;
                    end else begin
                        nr = hex_feed(nst_reg, c, crem_reg);
                        crem_next = nr.v;
                        nst_next  = nr.st;
                    end
                end
                PH_CGAP: begin
                    skip_next = (skip_reg != '0) ? skip_reg - 2'd1 : skip_reg;
                    if (skip_next == '0) begin
                        phase_next = PH_CSIZE;
                        crem_next  = '0;
                        nst_next   = '0;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // Hold parser state; update on each popped request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HDR;
            lpos_reg         <= '0;
            nmf_reg          <= 2'b11;
            vmp_reg          <= '0;
            status_reg       <= '0;
            clen_reg         <= '0;
            lpres_reg        <= 1'b0;
            chunked_reg      <= 1'b0;
            crem_reg         <= '0;
            dcount_reg       <= '0;
            skip_reg         <= '0;
            pfx_reg          <= 1'b1;
            on_status_reg    <= 1'b0;
            colon_reg        <= 1'b0;
            past_first_reg   <= 1'b0;
            space_seen_reg   <= 1'b0;
            body_started_reg <= 1'b0;
            kind_reg         <= HK_NONE;
            nst_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg        <= phase_next;
                lpos_reg         <= lpos_next;
                nmf_reg          <= nmf_next;
                vmp_reg          <= vmp_next;
                status_reg       <= status_next;
                clen_reg         <= clen_next;
                lpres_reg        <= lpres_next;
                chunked_reg      <= chunked_next;
                crem_reg         <= crem_next;
                dcount_reg       <= dcount_next;
                skip_reg         <= skip_next;
                pfx_reg          <= pfx_next;
                on_status_reg    <= on_status_next;
                colon_reg        <= colon_next;
                past_first_reg   <= past_first_next;
                space_seen_reg   <= space_seen_next;
                body_started_reg <= body_started_next;
                kind_reg         <= kind_next;
                nst_reg          <= nst_next;
                m_valid_reg      <= res_valid;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge aclk) begin
        if (q_pop && res_valid) begin
            m_data_reg <= res_data;
        end
    end

endmodule

// ===== rtl/core/http_response_stream_parser_top.sv =====
// HTTP/1.1 response parser: takes the response one byte per request and returns body bytes
// (plain, length-limited or chunk-decoded) and, on end of stream, one summary with status code,
// body length and error flag. A byte is taken every cycle while the four-entry request queue
// has room; the byte is written into the queue when it is taken, and the output register
// loads its result from the queue head when the parser pops that byte. While a result waits
// on m_ready the parser holds, and after four more bytes the queue is full and s_ready drops.
// The parser updates its whole state once per byte, which sets the rate at one byte per cycle
// while no result waits on m_ready.
module http_response_stream_parser_top
    import hrsp_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    entry_t front_entry;
    entry_t q_head;
    logic   q_not_full;
    logic   q_not_empty;
    logic   q_pop;

    assign s_ready = q_not_full;

    hrsp_front u_front (
        .in_data (s_data),
        .entry   (front_entry)
    );

    hrsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && q_not_full),
        .push_entry (front_entry),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    hrsp_back #(
        .LW (LEN_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`include "http_response_stream_parser_top_assert.svh"

    `HRSP_ASSERT_IMPLIES(a_one_kind, m_valid, m_data.body_valid ^ m_data.done_res)
    `HRSP_ASSERT_IMPLIES(a_body_clean, m_valid && m_data.body_valid, m_data.status_code == 10'd0 && m_data.body_length == 32'd0 && !m_data.is_error)
    `HRSP_ASSERT_IMPLIES(a_err_flag, m_valid && m_data.done_res, m_data.is_error == (m_data.status_code >= ERR_STATUS))
    `HRSP_ASSERT_NEXT(a_reset_idle, !aresetn, !m_valid && s_ready)

endmodule
